### rtl/core/qva_pkg.sv
// Shared types and codes for the QoS vote aggregator.
package qva_pkg;

   localparam int LEVEL_W = 32;
   localparam int SLOT_W  = 5;
   localparam int TYPE_W  = 2;
   localparam int MODE_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [TYPE_W-1:0] REQ_ADD    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_UPDATE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd2;

   localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SUM = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY   = 2'd2;

   localparam logic signed [LEVEL_W-1:0] LEVEL_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [LEVEL_W-1:0] LEVEL_MIN   = 32'sh8000_0000;
   localparam logic signed [LEVEL_W-1:0] DEFAULT_MARK = -32'sd1;

   typedef struct packed {
      logic                      active;
      logic signed [LEVEL_W-1:0] level;
   } vote_type;

   typedef struct packed {
      logic                      any;
      logic signed [LEVEL_W-1:0] lo;
      logic signed [LEVEL_W-1:0] hi;
   } agg_type;

endpackage

### rtl/core/qva_fold.sv
// Shared compare-add unit: folds one vote into the running min, max and sum.
module qva_fold
   import qva_pkg::*;
#(
   parameter int SUM_W = 37
) (
   input  agg_type                  acc_in,
   input  logic signed [SUM_W-1:0]  sum_in,
   input  vote_type                 vote,
   output agg_type                  acc_out,
   output logic signed [SUM_W-1:0]  sum_out
);

   always_comb begin
      acc_out = acc_in;
      sum_out = sum_in;
      if (vote.active) begin
         acc_out.any = 1'b1;
         acc_out.lo  = (!acc_in.any || (vote.level < acc_in.lo)) ? vote.level : acc_in.lo;
         acc_out.hi  = (!acc_in.any || (vote.level > acc_in.hi)) ? vote.level : acc_in.hi;
         sum_out     = sum_in + SUM_W'(vote.level);
      end
   end

endmodule

### rtl/core/qva_slot_store.sv
// Slot table: active bits in flops, levels in a one-read one-write memory.
module qva_slot_store
   import qva_pkg::*;
#(
   parameter int SLOTS = 32,
   localparam int IDX_W = $clog2(SLOTS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output vote_type         rd_vote,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  vote_type         wr_vote
);

   logic [SLOTS-1:0]          slot_active_ff;
   logic signed [LEVEL_W-1:0] slot_level_mem [SLOTS];
   logic                      rd_active_ff;
   logic signed [LEVEL_W-1:0] rd_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_active_ff <= '0;
         rd_active_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            slot_active_ff[wr_addr] <= wr_vote.active;
         end
         if (rd_en) begin
            rd_active_ff <= slot_active_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_level_mem[wr_addr] <= wr_vote.level;
      end
      if (rd_en) begin
         rd_level_ff <= slot_level_mem[rd_addr];
      end
   end

   assign rd_vote.active = rd_active_ff;
   assign rd_vote.level  = rd_level_ff;

endmodule

### rtl/core/qos_vote_aggregator.sv
// QoS vote aggregator top level: request sequencer, slot scan and result register.
//
//  channel  | ports                                           | handshake
//  request  | req_type, req_slot_id, req_request_value       | req_valid / req_ready
//  response | rsp_target_level, rsp_changed, rsp_status      | rsp_valid / rsp_ready
//  csr      | csr_index, csr_wdata                           | csr_wr_en, no stall
//
// A request is taken only in IDLE, so a new one waits until the last has left EMIT; the
// scan feeds one slot per cycle from the level memory through the fold unit.
// The next request is taken while the response waits, and a finished result holds
// in EMIT until the output register is free.
// Reset clears all votes, the CSRs, the state and the handshake state; no clearing pass runs.
module qos_vote_aggregator
   import qva_pkg::*;
#(
   parameter int SLOTS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [TYPE_W-1:0]         req_type,
   input  logic [SLOT_W-1:0]         req_slot_id,
   input  logic signed [LEVEL_W-1:0] req_request_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [LEVEL_W-1:0] rsp_target_level,
   output logic                      rsp_changed,
   output logic                      rsp_status,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [LEVEL_W-1:0]        csr_wdata
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int SUM_W  = LEVEL_W + $clog2(SLOTS);
   localparam int WIDE_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(LEVEL_MAX);
   localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(LEVEL_MIN);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_APPLY  = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_FOLD_B = 7'b0001000,
      ST_FOLD_A = 7'b0010000,
      ST_FINAL  = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [MODE_W-1:0]         mode_ff, mode_in;
   logic signed [LEVEL_W-1:0] default_ff, default_in;
   logic signed [LEVEL_W-1:0] empty_ff, empty_in;

   logic [TYPE_W-1:0]         type_ff, type_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic                      in_range_ff, in_range_in;
   logic signed [LEVEL_W-1:0] raw_ff, raw_in;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   vote_type                  old_ff, old_in;
   vote_type                  new_ff, new_in;
   logic                      status_ff, status_in;

   logic [CNT_W-1:0]          scan_cnt_ff, scan_cnt_in;
   logic                      rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]          rd_idx_ff, rd_idx_in;
   agg_type                   acc_ff, acc_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   agg_type                   res_ff, res_in;
   logic signed [SUM_W-1:0]   res_sum_ff, res_sum_in;
   logic signed [LEVEL_W-1:0] before_ff, before_in;
   logic signed [LEVEL_W-1:0] after_ff, after_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic                      rsp_changed_ff, rsp_changed_in;
   logic                      rsp_status_ff, rsp_status_in;

   logic [WIDE_W-1:0]         req_slot_wide;
   logic                      req_in_range;
   logic                      rd_en;
   logic [IDX_W-1:0]          rd_addr;
   vote_type                  rd_vote;
   logic                      wr_en;
   vote_type                  fold_vote;
   agg_type                   fold_acc;
   logic signed [SUM_W-1:0]   fold_sum;
   logic signed [LEVEL_W-1:0] final_level;
   vote_type                  look_vote;
   logic                      look_ok;

   assign req_slot_wide = WIDE_W'(req_slot_id);
   assign req_in_range  = req_slot_wide < WIDE_W'(SLOTS);
   assign look_vote     = in_range_ff ? rd_vote : '{active: 1'b0, level: '0};

   // Activity must match the request: add wants an idle slot, update and remove an active one.
   always_comb begin
      look_ok = 1'b1;
      if (type_ff == REQ_ADD) begin
         look_ok = in_range_ff && !look_vote.active;
      end else if (type_ff == REQ_UPDATE || type_ff == REQ_REMOVE) begin
         look_ok = in_range_ff && look_vote.active;
      end
   end

   // Final aggregate from the folded min, max and sum.
   always_comb begin
      final_level = empty_ff;
      if (res_ff.any) begin
         unique case (mode_ff)
            MODE_MIN: final_level = res_ff.lo;
            MODE_MAX: final_level = res_ff.hi;
            MODE_SUM: begin
               if (res_sum_ff > SAT_MAX) begin
                  final_level = LEVEL_MAX;
               end else if (res_sum_ff < SAT_MIN) begin
                  final_level = LEVEL_MIN;
               end else begin
                  final_level = res_sum_ff[LEVEL_W-1:0];
               end
            end
            default: final_level = DEFAULT_MARK;
         endcase
      end
   end

   // Fold input: the scanned slot (minus the slot acted on), then the old and new vote of it.
   always_comb begin
      fold_vote = rd_vote;
      if (state_ff == ST_FOLD_B) begin
         fold_vote = old_ff;
      end else if (state_ff == ST_FOLD_A) begin
         fold_vote = new_ff;
      end else if (in_range_ff && rd_idx_ff == idx_ff) begin
         fold_vote.active = 1'b0;
      end
   end

   always_comb begin
      mode_in        = mode_ff;
      default_in     = default_ff;
      empty_in       = empty_ff;
      state_in       = state_ff;
      type_in        = type_ff;
      idx_in         = idx_ff;
      in_range_in    = in_range_ff;
      raw_in         = raw_ff;
      level_in       = level_ff;
      old_in         = old_ff;
      new_in         = new_ff;
      status_in      = status_ff;
      scan_cnt_in    = scan_cnt_ff;
      rd_pend_in     = rd_pend_ff;
      rd_idx_in      = rd_idx_ff;
      acc_in         = acc_ff;
      sum_in         = sum_ff;
      res_in         = res_ff;
      res_sum_in     = res_sum_ff;
      before_in      = before_ff;
      after_in       = after_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_status_in  = rsp_status_ff;
      rd_en          = 1'b0;
      rd_addr        = scan_cnt_ff[IDX_W-1:0];
      wr_en          = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:    mode_in    = csr_wdata[MODE_W-1:0];
            CSR_DEFAULT: default_in = csr_wdata;
            CSR_EMPTY:   empty_in   = csr_wdata;
            default:     ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = req_slot_wide[IDX_W-1:0];
            if (req_valid) begin
               rd_en       = 1'b1;
               type_in     = req_type;
               idx_in      = req_slot_wide[IDX_W-1:0];
               in_range_in = req_in_range;
               raw_in      = req_request_value;
               level_in    = (req_request_value == DEFAULT_MARK) ? default_ff
                                                                 : req_request_value;
               state_in    = ST_APPLY;
            end
         end
         ST_APPLY: begin
            old_in    = look_vote;
            new_in    = look_vote;
            status_in = !look_ok;
            if (look_ok) begin
               if (type_ff == REQ_ADD) begin
                  new_in = '{active: 1'b1, level: level_ff};
               end else if (type_ff == REQ_UPDATE && raw_ff != look_vote.level) begin
                  new_in.level = level_ff;
               end else if (type_ff == REQ_REMOVE) begin
                  new_in.active = 1'b0;
               end
            end
            wr_en       = in_range_ff && look_ok;
            scan_cnt_in = '0;
            rd_pend_in  = 1'b0;
            acc_in      = '{any: 1'b0, lo: '0, hi: '0};
            sum_in      = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            rd_pend_in = 1'b0;
            rd_idx_in  = scan_cnt_ff[IDX_W-1:0];
            if (scan_cnt_ff < CNT_W'(SLOTS)) begin
               rd_en       = 1'b1;
               rd_pend_in  = 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
            if (rd_pend_ff) begin
               acc_in = fold_acc;
               sum_in = fold_sum;
               if (scan_cnt_ff == CNT_W'(SLOTS)) begin
                  state_in = ST_FOLD_B;
               end
            end
         end
         ST_FOLD_B: begin
            res_in     = fold_acc;
            res_sum_in = fold_sum;
            state_in   = ST_FOLD_A;
         end
         ST_FOLD_A: begin
            before_in  = final_level;
            res_in     = fold_acc;
            res_sum_in = fold_sum;
            state_in   = ST_FINAL;
         end
         ST_FINAL: begin
            after_in = final_level;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_level_in   = after_ff;
               rsp_changed_in = after_ff != before_ff;
               rsp_status_in  = status_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_MIN;
         default_ff   <= '0;
         empty_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         default_ff   <= default_in;
         empty_ff     <= empty_in;
         rd_pend_ff   <= rd_pend_in;
         scan_cnt_ff  <= scan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff        <= type_in;
      idx_ff         <= idx_in;
      in_range_ff    <= in_range_in;
      raw_ff         <= raw_in;
      level_ff       <= level_in;
      old_ff         <= old_in;
      new_ff         <= new_in;
      status_ff      <= status_in;
      rd_idx_ff      <= rd_idx_in;
      acc_ff         <= acc_in;
      sum_ff         <= sum_in;
      res_ff         <= res_in;
      res_sum_ff     <= res_sum_in;
      before_ff      <= before_in;
      after_ff       <= after_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_status_ff  <= rsp_status_in;
   end

   qva_slot_store #(
      .SLOTS (SLOTS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_vote (rd_vote),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_vote (new_in)
   );

   qva_fold #(
      .SUM_W (SUM_W)
   ) u_fold (
      .acc_in  (acc_ff),
      .sum_in  (sum_ff),
      .vote    (fold_vote),
      .acc_out (fold_acc),
      .sum_out (fold_sum)
   );

   assign req_ready        = state_ff == ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_level = rsp_level_ff;
   assign rsp_changed      = rsp_changed_ff;
   assign rsp_status       = rsp_status_ff;

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a vote is in flight");

   a_reject_no_change : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> !rsp_changed)
      else $error("rejected request reported a changed target");

   a_scan_bound : assert property (@(posedge clock) disable iff (reset)
      scan_cnt_ff <= CNT_W'(SLOTS))
      else $error("scan counter ran past the table");

   a_emit_holds : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && !rsp_ready) |=>
         (state_ff == ST_EMIT && $stable(rsp_target_level)))
      else $error("result overwrote a beat not yet taken");

endmodule
